### hw/rtl/bus_pkg.sv
// Shared types and constants of the block upload sequencer.
// Used by bus_front, bus_back and block_upload_sequencer; depends on nothing.
`default_nettype none
package bus_pkg;

	localparam int unsigned MaxBlockBytes = 1024;
	localparam int unsigned ChunkBytes    = 512;
	localparam int unsigned HelloMinSize  = 8;

	localparam int unsigned InDataW  = 144;
	localparam int unsigned OutDataW = 120;

	// Event type codes of the bootloader protocol.
	localparam logic [15:0] EV_HELLO        = 16'd1;
	localparam logic [15:0] EV_START_ACK    = 16'd3;
	localparam logic [15:0] EV_DATA_ACK     = 16'd6;
	localparam logic [15:0] EV_PROGRAM_ACK  = 16'd9;
	localparam logic [15:0] EV_ACTIVATE_ACK = 16'd12;

	// Input op codes.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_EVENT = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Result action codes.
	localparam logic [2:0] ACT_START    = 3'd0;
	localparam logic [2:0] ACT_CHUNK    = 3'd1;
	localparam logic [2:0] ACT_PROGRAM  = 3'd2;
	localparam logic [2:0] ACT_ACTIVATE = 3'd3;
	localparam logic [2:0] ACT_FINISHED = 3'd4;

	// Finished status codes.
	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_PROTOCOL = 3'd1;
	localparam logic [2:0] STS_RETRIES  = 3'd2;
	localparam logic [2:0] STS_CRC      = 3'd3;
	localparam logic [2:0] STS_ARGS     = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_MEM_TYPE    = 3'd0;
	localparam logic [2:0] REG_MEM_BANK    = 3'd1;
	localparam logic [2:0] REG_TIMEOUT     = 3'd2;
	localparam logic [2:0] REG_MSG_RETRIES = 3'd3;
	localparam logic [2:0] REG_BLK_RETRIES = 3'd4;

	typedef enum logic [1:0] {
		KIND_START,
		KIND_EVENT,
		KIND_TICK
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] image_length;
		logic [15:0] image_crc;
		logic [15:0] event_type;
		logic [9:0]  event_size;
		logic [31:0] first_word;
		logic [31:0] second_word;
	} item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] block_number;
		logic [9:0]  chunk_offset;
		logic [9:0]  chunk_length;
		logic [31:0] image_offset;
		logic [9:0]  copy_length;
		logic [15:0] crc_value;
		logic [2:0]  status;
	} res_t;

	// Handshake between the front queue and the sequencer.
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

endpackage
`default_nettype wire

### hw/rtl/bus_front.sv
// Front end: accepts input words, classifies them and holds them in a two-entry queue.
// Depends on bus_pkg.
`default_nettype none
module bus_front import bus_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] in_op,
	input  wire item_t      in_item,
	output queue_out_t      q_out,
	input  wire logic       q_pop
);

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	item_t      cls;

	// Classify the op; an unknown op is accepted and dropped.
	always_comb begin
		cls = in_item;
		case (in_op)
			OP_START: cls.kind = KIND_START;
			OP_EVENT: cls.kind = KIND_EVENT;
			default:  cls.kind = KIND_TICK;
		endcase
	end

	assign in_ready    = (count_q != 2'd2);
	assign push        = in_valid && in_ready && (in_op != 2'd3);
	assign pop         = q_pop && (count_q != 2'd0);
	assign q_out.valid = (count_q != 2'd0);
	assign q_out.item  = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bus_back.sv
// Back end: the upload sequencer with its block-count divider and the output register.
// Depends on bus_pkg; fed by bus_front.
`default_nettype none
module bus_back import bus_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire queue_out_t  q_in,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output res_t             out_res
);

	typedef enum logic [2:0] {
		ST_FETCH, ST_DIV, ST_CHK, ST_OFS, ST_CPY, ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_HELLO, PH_START, PH_DATA, PH_PROGRAM, PH_ACTIVATE
	} phase_t;

	typedef enum logic [2:0] {
		DO_NONE, DO_FINISH, DO_START, DO_CHUNK, DO_PROGRAM, DO_ACTIVATE, DO_DIV
	} do_t;

	// Configuration registers (the memory type and bank bytes are stored but not used in this block).
	logic [7:0]  mem_type_q, mem_bank_q, msg_retries_q, blk_retries_q;
	logic [15:0] timeout_q;

	state_t      state_q;
	phase_t      phase_q, phase_n;
	logic [31:0] block_bytes_q, block_bytes_n;
	logic [31:0] allowed_q, allowed_n;
	logic [31:0] needed_q;
	logic [31:0] block_q, block_n;
	logic [32:0] base_q, base_n;
	logic [10:0] coff_q, coff_n;
	logic [7:0]  msg_att_q, msg_att_n;
	logic [7:0]  blk_att_q, blk_att_n;
	logic [15:0] wait_q, wait_n;
	logic [31:0] length_q, length_n;
	logic [15:0] crc_q, crc_n;
	do_t         act;
	logic [2:0]  fin_status;
	logic        want_bf, want_mf, want_bb, want_bd;

	logic [32:0] num_q;
	logic [31:0] rem_q;
	logic [5:0]  div_cnt_q;
	logic [32:0] rem_try;
	logic        rem_ge;

	logic [32:0] ioff_s1;
	logic [9:0]  clen_s1;
	logic [31:0] rem_bytes;
	logic [9:0]  clen_c;
	logic [10:0] coff_sum;
	logic [15:0] limit;
	logic [15:0] wait_inc;
	logic [31:0] copy_diff;
	logic [9:0]  copy_c;
	item_t       it;
	res_t        res_q;
	res_t        res_n;
	logic        fetch;
	logic        emit_go;

	assign it      = q_in.item;
	assign fetch   = (state_q == ST_FETCH) && q_in.valid;
	assign q_pop   = fetch;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid || out_ready);

	// Chunk length from the current offset.
	assign rem_bytes = block_bytes_q - {21'd0, coff_q};
	assign clen_c    = (rem_bytes > 32'(ChunkBytes)) ? 10'(ChunkBytes) : rem_bytes[9:0];
	assign coff_sum  = coff_q + {1'b0, clen_c};
	assign limit     = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
	assign wait_inc  = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;

	// One restoring division step.
	assign rem_try = {rem_q, num_q[32]};
	assign rem_ge  = (rem_try >= {1'b0, block_bytes_q});

	// Bytes of the chunk that lie inside the image.
	assign copy_diff = length_q - ioff_s1[31:0];
	always_comb begin
		if (ioff_s1 < {1'b0, length_q}) begin
			copy_c = (copy_diff > {22'd0, clen_s1}) ? clen_s1 : copy_diff[9:0];
		end else begin
			copy_c = 10'd0;
		end
	end

	// Next-state decision for a fetched word or for the check after the division.
	always_comb begin
		phase_n       = phase_q;
		block_bytes_n = block_bytes_q;
		allowed_n     = allowed_q;
		block_n       = block_q;
		base_n        = base_q;
		coff_n        = coff_q;
		msg_att_n     = msg_att_q;
		blk_att_n     = blk_att_q;
		wait_n        = wait_q;
		length_n      = length_q;
		crc_n         = crc_q;
		act           = DO_NONE;
		fin_status    = STS_OK;
		want_bf       = 1'b0;
		want_mf       = 1'b0;
		want_bb       = 1'b0;
		want_bd       = 1'b0;

		if (state_q == ST_CHK) begin
			if ((needed_q > allowed_q) || (block_bytes_q > 32'(MaxBlockBytes))) begin
				act        = DO_FINISH;
				fin_status = STS_ARGS;
			end else begin
				block_n = 32'd0;
				base_n  = 33'd0;
				want_bb = 1'b1;
			end
		end else if (fetch) begin
			case (it.kind)
				KIND_START: begin
					if (phase_q == PH_IDLE) begin
						length_n = it.image_length;
						crc_n    = it.image_crc;
						if (it.image_length == 32'd0) begin
							act        = DO_FINISH;
							fin_status = STS_ARGS;
						end else begin
							phase_n = PH_HELLO;
							wait_n  = 16'd0;
						end
					end
				end
				KIND_EVENT: begin
					case (phase_q)
						PH_HELLO: begin
							if ((it.event_type != EV_HELLO) ||
								(it.event_size < 10'(HelloMinSize)) ||
								(it.first_word == 32'd0)) begin
								act        = DO_FINISH;
								fin_status = STS_PROTOCOL;
							end else begin
								block_bytes_n = it.first_word;
								allowed_n     = it.second_word;
								act           = DO_DIV;
							end
						end
						PH_START: begin
							if (it.event_type != EV_START_ACK) want_bf = 1'b1;
							else want_bd = 1'b1;
						end
						PH_DATA: begin
							if (it.event_type != EV_DATA_ACK) begin
								want_mf = 1'b1;
							end else begin
								coff_n = coff_sum;
								if ({21'd0, coff_sum} < block_bytes_q) begin
									msg_att_n = 8'd1;
									act       = DO_CHUNK;
								end else begin
									act = DO_PROGRAM;
								end
							end
						end
						PH_PROGRAM: begin
							if (it.event_type != EV_PROGRAM_ACK) begin
								want_bf = 1'b1;
							end else begin
								block_n = block_q + 32'd1;
								base_n  = base_q + {1'b0, block_bytes_q};
								if ((block_q + 32'd1) < needed_q) want_bb = 1'b1;
								else act = DO_ACTIVATE;
							end
						end
						PH_ACTIVATE: begin
							act        = DO_FINISH;
							fin_status = (it.event_type == EV_ACTIVATE_ACK) ? STS_OK : STS_CRC;
						end
						default: ;
					endcase
				end
				default: begin
					if (phase_q != PH_IDLE) begin
						wait_n = wait_inc;
						if (wait_inc >= limit) begin
							case (phase_q)
								PH_HELLO: begin
									act        = DO_FINISH;
									fin_status = STS_PROTOCOL;
								end
								PH_START:   want_bf = 1'b1;
								PH_DATA:    want_mf = 1'b1;
								PH_PROGRAM: want_bf = 1'b1;
								PH_ACTIVATE: begin
									act        = DO_FINISH;
									fin_status = STS_CRC;
								end
								default: ;
							endcase
						end
					end
				end
			endcase
		end

		// Start of the data phase of a block.
		if (want_bd) begin
			coff_n = 11'd0;
			if (msg_retries_q == 8'd0) begin
				want_bf = 1'b1;
			end else begin
				msg_att_n = 8'd1;
				act       = DO_CHUNK;
			end
		end
		// Failed chunk send.
		if (want_mf) begin
			if (msg_att_q < msg_retries_q) begin
				msg_att_n = msg_att_q + 8'd1;
				act       = DO_CHUNK;
			end else begin
				want_bf = 1'b1;
			end
		end
		// Failed block attempt.
		if (want_bf) begin
			if (blk_att_q < blk_retries_q) begin
				blk_att_n = blk_att_q + 8'd1;
				act       = DO_START;
			end else begin
				act        = DO_FINISH;
				fin_status = STS_RETRIES;
			end
		end
		// First attempt of a new block.
		if (want_bb) begin
			if (blk_retries_q == 8'd0) begin
				act        = DO_FINISH;
				fin_status = STS_RETRIES;
			end else begin
				blk_att_n = 8'd1;
				act       = DO_START;
			end
		end

		case (act)
			DO_FINISH:   begin phase_n = PH_IDLE;     wait_n = 16'd0; end
			DO_START:    begin phase_n = PH_START;    wait_n = 16'd0; end
			DO_CHUNK:    begin phase_n = PH_DATA;     wait_n = 16'd0; end
			DO_PROGRAM:  begin phase_n = PH_PROGRAM;  wait_n = 16'd0; end
			DO_ACTIVATE: begin phase_n = PH_ACTIVATE; wait_n = 16'd0; end
			default: ;
		endcase
	end

	// Descriptor for the decided action, or the chunk descriptor in its last step.
	always_comb begin
		res_n = '0;
		if (state_q == ST_CPY) begin
			res_n.action       = ACT_CHUNK;
			res_n.block_number = block_q;
			res_n.chunk_offset = coff_q[9:0];
			res_n.chunk_length = clen_s1;
			res_n.image_offset = ioff_s1[31:0];
			res_n.copy_length  = copy_c;
		end else begin
			case (act)
				DO_FINISH: begin
					res_n.action = ACT_FINISHED;
					res_n.status = fin_status;
				end
				DO_START: begin
					res_n.action       = ACT_START;
					res_n.block_number = block_n;
				end
				DO_PROGRAM: begin
					res_n.action       = ACT_PROGRAM;
					res_n.block_number = block_q;
				end
				DO_ACTIVATE: begin
					res_n.action    = ACT_ACTIVATE;
					res_n.crc_value = crc_q;
				end
				default: ;
			endcase
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_type_q    <= 8'd0;
			mem_bank_q    <= 8'd0;
			timeout_q     <= 16'd1000;
			msg_retries_q <= 8'd3;
			blk_retries_q <= 8'd3;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MEM_TYPE:    mem_type_q    <= cfg_data[7:0];
				REG_MEM_BANK:    mem_bank_q    <= cfg_data[7:0];
				REG_TIMEOUT:     timeout_q     <= cfg_data;
				REG_MSG_RETRIES: msg_retries_q <= cfg_data[7:0];
				REG_BLK_RETRIES: blk_retries_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Sequencer state, divider and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_FETCH;
			phase_q       <= PH_IDLE;
			block_bytes_q <= 32'd0;
			allowed_q     <= 32'd0;
			needed_q      <= 32'd0;
			block_q       <= 32'd0;
			base_q        <= 33'd0;
			coff_q        <= 11'd0;
			msg_att_q     <= 8'd0;
			blk_att_q     <= 8'd0;
			wait_q        <= 16'd0;
			length_q      <= 32'd0;
			crc_q         <= 16'd0;
			num_q         <= 33'd0;
			rem_q         <= 32'd0;
			div_cnt_q     <= 6'd0;
			ioff_s1       <= 33'd0;
			clen_s1       <= 10'd0;
			res_q         <= '0;
			out_valid     <= 1'b0;
			out_res       <= '0;
		end else begin
			case (state_q)
				ST_FETCH, ST_CHK: begin
					if (fetch || state_q == ST_CHK) begin
						phase_q       <= phase_n;
						block_bytes_q <= block_bytes_n;
						allowed_q     <= allowed_n;
						block_q       <= block_n;
						base_q        <= base_n;
						coff_q        <= coff_n;
						msg_att_q     <= msg_att_n;
						blk_att_q     <= blk_att_n;
						wait_q        <= wait_n;
						length_q      <= length_n;
						crc_q         <= crc_n;
						res_q         <= res_n;
						case (act)
							DO_FINISH, DO_START, DO_PROGRAM, DO_ACTIVATE: state_q <= ST_EMIT;
							DO_CHUNK: state_q <= ST_OFS;
							DO_DIV: begin
								num_q     <= {1'b0, length_q} + {1'b0, it.first_word} - 33'd1;
								rem_q     <= 32'd0;
								div_cnt_q <= 6'd0;
								state_q   <= ST_DIV;
							end
							default: state_q <= ST_FETCH;
						endcase
					end
				end
				ST_DIV: begin
					rem_q     <= rem_ge ? 32'(rem_try - {1'b0, block_bytes_q}) : rem_try[31:0];
					num_q     <= {num_q[31:0], rem_ge};
					div_cnt_q <= div_cnt_q + 6'd1;
					// The last quotient bit completes the block count.
					if (div_cnt_q == 6'd32) begin
						needed_q <= num_q[31:0] << 1 | {31'd0, rem_ge};
						state_q  <= ST_CHK;
					end
				end
				ST_OFS: begin
					ioff_s1  <= base_q + {22'd0, coff_q};
					clen_s1  <= clen_c;
					state_q  <= ST_CPY;
				end
				ST_CPY: begin
					res_q   <= res_n;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_res <= res_q;
						state_q <= ST_FETCH;
					end
				end
				default: state_q <= ST_FETCH;
			endcase
			// Output valid: set when a descriptor moves out, cleared when taken.
			if (emit_go) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/block_upload_sequencer.sv
// Block upload sequencer, built from a front queue (bus_front) and a sequencer (bus_back).
// Depends on bus_pkg.
//
// A start word stores the image length and CRC; the block then follows the bootloader
// protocol and emits one descriptor word per step: start block, data chunk, program,
// activate or finished. A word that produces no descriptor is popped from the head of the
// input queue; start block, program, activate and finished descriptors pass through
// res_q into the output register after their word is taken from the queue, and a data
// chunk also passes ST_OFS and ST_CPY, since its image offset and copy length are formed
// in two registered steps. The hello event runs a restoring divider for the block count,
// one quotient bit per cycle, and then checks the count. A full output register holds the
// sequencer until the word is taken. A two-word input queue and the output register let
// the input and output sides stall independently.
`default_nettype none
module block_upload_sequencer import bus_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wen,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// image_length, image_crc, event_type, event_size, first_word, second_word
	input  wire logic [InDataW-1:0]  s_tdata,
	// op
	input  wire logic [1:0]          s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// block_number, chunk_offset, chunk_length, image_offset, copy_length, crc_value, status
	output logic [OutDataW-1:0]      m_tdata,
	// action
	output logic [2:0]               m_tuser
);

	item_t      in_item;
	queue_out_t q_out;
	logic       q_pop;
	res_t       res;

	// Unpack the input word.
	always_comb begin
		in_item              = '0;
		in_item.image_length = s_tdata[31:0];
		in_item.image_crc    = s_tdata[47:32];
		in_item.event_type   = s_tdata[63:48];
		in_item.event_size   = s_tdata[73:64];
		in_item.first_word   = s_tdata[105:74];
		in_item.second_word  = s_tdata[137:106];
	end

	bus_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_item  (in_item),
		.q_out    (q_out),
		.q_pop    (q_pop)
	);

	bus_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_in      (q_out),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// Pack the output word.
	assign m_tuser = res.action;
	assign m_tdata = {7'd0, res.status, res.crc_value, res.copy_length, res.image_offset,
		res.chunk_length, res.chunk_offset, res.block_number};

endmodule
`default_nettype wire
